// ===== hdl/adu_pkg.sv =====
`default_nettype none
package adu_pkg;

    localparam int DATA_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 12;
    localparam int MID_DEPTH_DEF  = 4;
    localparam int OUT_DEPTH_DEF  = 2;

    // widest intermediate result: DATA_WIDTH up to 32, FRAC_BITS up to 24
    localparam int RES_W = 34;
    localparam int FR_W  = 24;
    localparam int REG_W = 15;
    localparam int IDX_W = 2;

    localparam logic [REG_W-1:0] THRESH_RST = 15'd3277;
    localparam int LEAKY_MUL = 655;

    // Q1.30 unity for the exponential datapath
    localparam logic [30:0] Q_ONE = 31'h4000_0000;

    typedef enum logic [2:0] {
        MODE_RELU   = 3'd0,
        MODE_LEAKY  = 3'd1,
        MODE_TANH   = 3'd2,
        MODE_SIG    = 3'd3,
        MODE_SATLIN = 3'd4,
        MODE_LINEAR = 3'd5,
        MODE_ADAPT  = 3'd6
    } t_mode;

    typedef enum logic [IDX_W-1:0] {
        CFG_MAX_ERROR = 2'd0,
        CFG_THRESHOLD = 2'd1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KIND_DIRECT  = 2'd0,
        KIND_TANH    = 2'd1,
        KIND_SIGMOID = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind                    kind;
        logic                     der;
        logic                     neg;
        logic                     zero_e;
        logic [4:0]               n;
        logic signed [RES_W-1:0]  res;
    } t_ctl;

    typedef struct packed {
        t_ctl            ctl;
        logic [FR_W-1:0] fr;
    } t_item;

    // exp(-1) in Q30 via the truncating series; with y = 1 each term is term/k
    function automatic logic [30:0] exp_one();
        logic [63:0] pos;
        logic [63:0] ng;
        logic [63:0] term;
        pos  = 64'd1 << 30;
        ng   = 64'd0;
        term = 64'd1 << 30;
        for (int Kt = 1; Kt <= 16; Kt++) begin
            term = term / Kt;
            if (Kt % 2 == 1) ng = ng + term;
            else pos = pos + term;
        end
        return 31'(pos - ng);
    endfunction

    localparam logic [30:0] E1 = exp_one();

endpackage
`default_nettype wire

// ===== hdl/adu_fifo.sv =====
`default_nettype none
module adu_fifo import adu_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output logic [WIDTH-1:0]      o_rdata
);
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW:0]      r_wp;
    logic [AW:0]      r_rp;

    assign o_empty = (r_wp == r_rp);
    assign o_full  = (r_wp[AW] != r_rp[AW]) && (r_wp[AW-1:0] == r_rp[AW-1:0]);
    assign o_rdata = r_mem[r_rp[AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (i_push && !o_full) r_wp <= r_wp + 1'b1;
            if (i_pop && !o_empty) r_rp <= r_rp + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) r_mem[r_wp[AW-1:0]] <= i_wdata;
    end
endmodule
`default_nettype wire

// ===== hdl/adu_front.sv =====
`default_nettype none
module adu_front import adu_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    output logic                       o_full,
    input  wire logic [DATA_WIDTH-1:0] i_value_in,
    input  wire logic [2:0]            i_mode,
    input  wire logic                  i_want_derivative,
    input  wire logic                  i_cfg_we,
    input  wire logic [IDX_W-1:0]      i_cfg_idx,
    input  wire logic [REG_W-1:0]      i_cfg_data,
    output logic                       o_valid,
    output t_item                      o_item,
    input  wire logic                  i_q_full
);
    localparam int DW = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int AX = DW + 1 + F;
    localparam logic signed [RES_W-1:0] ONE_S  = RES_W'(64'd1 << F);
    localparam logic signed [RES_W-1:0] HALF_S = RES_W'(64'd1 << (F - 1));
    localparam logic signed [RES_W-1:0] LK_D   =
        RES_W'(((64'd655 << F) + 64'd32768) >> 16);

    logic             r_valid;
    t_item            r_item;
    logic [REG_W-1:0] r_max_err;
    logic [REG_W-1:0] r_thresh;

    logic                    load;
    logic signed [DW-1:0]    x;
    logic signed [RES_W-1:0] xs;
    logic                    neg;
    logic [DW-1:0]           mag;
    logic [AX-1:0]           a_ext;
    logic signed [DW+12:0]   lkp;
    logic signed [DW+12:0]   lk_sh;
    logic                    slope2;
    logic signed [RES_W-1:0] band;
    logic signed [RES_W-1:0] sone;
    t_item                   n_item;

    assign o_full  = r_valid && i_q_full;
    assign load    = i_push && !o_full;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        x      = $signed(i_value_in);
        xs     = RES_W'(x);
        neg    = x[DW-1];
        mag    = neg ? DW'(-x) : DW'(x);
        slope2 = (r_max_err < r_thresh);
        band   = slope2 ? HALF_S : ONE_S;
        sone   = slope2 ? (ONE_S <<< 1) : ONE_S;
        lkp    = $signed({{13{x[DW-1]}}, x}) * $signed((DW+13)'(LEAKY_MUL))
                 + $signed((DW+13)'(32768));
        lk_sh  = lkp >>> 16;

        if (t_mode'(i_mode) == MODE_TANH) a_ext = AX'({mag, 1'b0});
        else a_ext = AX'(mag);

        n_item            = '0;
        n_item.ctl.kind   = KIND_DIRECT;
        n_item.ctl.der    = i_want_derivative;
        n_item.ctl.neg    = neg;
        n_item.ctl.zero_e = |(a_ext[AX-1:F] >> 5);
        n_item.ctl.n      = a_ext[F+4:F];
        n_item.fr         = FR_W'(a_ext[F-1:0]);

        unique case (i_mode)
            MODE_RELU: begin
                if (neg) n_item.ctl.res = '0;
                else n_item.ctl.res = i_want_derivative ? ONE_S : xs;
            end
            MODE_LEAKY: begin
                if (i_want_derivative) n_item.ctl.res = neg ? LK_D : ONE_S;
                else n_item.ctl.res = neg ? RES_W'(lk_sh) : xs;
            end
            MODE_TANH: n_item.ctl.kind = KIND_TANH;
            MODE_SIG:  n_item.ctl.kind = KIND_SIGMOID;
            MODE_SATLIN: begin
                if (i_want_derivative)
                    n_item.ctl.res = (xs > -ONE_S && xs < ONE_S) ? ONE_S : '0;
                else if (xs <= -ONE_S) n_item.ctl.res = -ONE_S;
                else if (xs >= ONE_S) n_item.ctl.res = ONE_S;
                else n_item.ctl.res = xs;
            end
            MODE_LINEAR: n_item.ctl.res = i_want_derivative ? ONE_S : xs;
            MODE_ADAPT: begin
                if (i_want_derivative)
                    n_item.ctl.res = (xs > -band && xs < band) ? sone : '0;
                else if (xs <= -band) n_item.ctl.res = -ONE_S;
                else if (xs >= band) n_item.ctl.res = ONE_S;
                else n_item.ctl.res = slope2 ? (xs <<< 1) : xs;
            end
            default: n_item.ctl.res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_max_err <= '0;
            r_thresh  <= THRESH_RST;
        end else begin
            if (load) r_valid <= 1'b1;
            else if (!i_q_full) r_valid <= 1'b0;
            if (i_cfg_we && i_cfg_idx == CFG_MAX_ERROR) r_max_err <= i_cfg_data;
            if (i_cfg_we && i_cfg_idx == CFG_THRESHOLD) r_thresh <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) r_item <= n_item;
    end
endmodule
`default_nettype wire

// ===== hdl/adu_back.sv =====
`default_nettype none
module adu_back import adu_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int OUT_DEPTH  = OUT_DEPTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_avail,
    input  wire t_item                  i_item,
    output logic                        o_take,
    input  wire logic                   i_pop,
    output logic                        o_empty,
    output logic [DATA_WIDTH-1:0]       o_value_out
);
    localparam int DW = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam logic [F:0] ONE_Q = (F+1)'(1) << F;
    localparam logic [2*F+1:0] HALF_P = (2*F+2)'(1) << (F - 1);
    localparam logic signed [RES_W-1:0] ONE_S = RES_W'(64'd1 << F);
    localparam logic signed [RES_W-1:0] HI_S  = RES_W'((64'd1 << (DW - 1)) - 1);
    localparam logic signed [RES_W-1:0] LO_S  = -RES_W'(64'd1 << (DW - 1));

    logic ofull;
    logic adv;

    // series stages
    logic        r_ser_v [0:16];
    t_ctl        r_ser_c [0:16];
    logic [30:0] r_ser_y [0:16];
    logic [30:0] r_ser_t [0:16];
    logic [31:0] r_ser_p [0:16];
    logic [31:0] r_ser_n [0:16];
    logic        r_prd_v [1:16];
    t_ctl        r_prd_c [1:16];
    logic [30:0] r_prd_q [1:16];
    logic [30:0] r_prd_y [1:16];
    logic [31:0] r_prd_p [1:16];
    logic [31:0] r_prd_n [1:16];
    // integer power stages
    logic        r_pw_v [0:31];
    t_ctl        r_pw_c [0:31];
    logic [30:0] r_pw_r [0:31];
    // divider stages
    logic        r_dv_v   [0:F+1];
    t_ctl        r_dv_c   [0:F+1];
    logic [31:0] r_dv_den [0:F+1];
    logic [31:0] r_dv_rem [0:F+1];
    logic [F:0]  r_dv_low [0:F+1];
    logic [F:0]  r_dv_q   [0:F+1];
    // product stage
    logic           r_ml_v;
    t_ctl           r_ml_c;
    logic [F:0]     r_ml_q;
    logic [2*F+1:0] r_ml_p;

    assign adv    = !ofull;
    assign o_take = adv && i_avail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ser_v[0] <= 1'b0;
        else if (adv) r_ser_v[0] <= o_take;
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ser_c[0] <= i_item.ctl;
            r_ser_y[0] <= 31'(i_item.fr[F-1:0]) << (30 - F);
            r_ser_t[0] <= Q_ONE;
            r_ser_p[0] <= 32'(Q_ONE);
            r_ser_n[0] <= '0;
        end
    end

    for (genvar k = 1; k <= 16; k++) begin : g_ser
        localparam int K = k;
        localparam logic [35:0] M = 36'(((64'd1 << 35) + K - 1) / K);
        logic [61:0] mul;
        logic [66:0] dq;
        logic [30:0] t;
        assign mul = r_ser_t[k-1] * r_ser_y[k-1];
        assign dq  = r_prd_q[k] * M;
        assign t   = dq[65:35];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_prd_v[k] <= 1'b0;
                r_ser_v[k] <= 1'b0;
            end else if (adv) begin
                r_prd_v[k] <= r_ser_v[k-1];
                r_ser_v[k] <= r_prd_v[k];
            end
        end
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_prd_c[k] <= r_ser_c[k-1];
                r_prd_q[k] <= mul[60:30];
                r_prd_y[k] <= r_ser_y[k-1];
                r_prd_p[k] <= r_ser_p[k-1];
                r_prd_n[k] <= r_ser_n[k-1];
                r_ser_c[k] <= r_prd_c[k];
                r_ser_y[k] <= r_prd_y[k];
                r_ser_t[k] <= t;
                // odd terms subtract, even terms add
                if (K % 2 == 1) begin
                    r_ser_p[k] <= r_prd_p[k];
                    r_ser_n[k] <= r_prd_n[k] + 32'(t);
                end else begin
                    r_ser_p[k] <= r_prd_p[k] + 32'(t);
                    r_ser_n[k] <= r_prd_n[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_pw_v[0] <= 1'b0;
        else if (adv) r_pw_v[0] <= r_ser_v[16];
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pw_c[0] <= r_ser_c[16];
            r_pw_r[0] <= 31'(r_ser_p[16] - r_ser_n[16]);
        end
    end

    // one rounded multiply by exp(-1) per integer unit of the argument
    for (genvar i = 0; i < 31; i++) begin : g_pw
        logic [61:0] pm;
        logic [61:0] pr;
        assign pm = r_pw_r[i] * E1;
        assign pr = (pm + (62'd1 << 29)) >> 30;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_pw_v[i+1] <= 1'b0;
            else if (adv) r_pw_v[i+1] <= r_pw_v[i];
        end
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_pw_c[i+1] <= r_pw_c[i];
                r_pw_r[i+1] <= (r_pw_c[i].n > 5'(i)) ? pr[30:0] : r_pw_r[i];
            end
        end
    end

    logic [30:0]   e_val;
    logic [31:0]   den0;
    logic [30:0]   a_sel;
    logic [F+31:0] num0;

    always_comb begin
        e_val = r_pw_c[31].zero_e ? '0 : r_pw_r[31];
        den0  = 32'(Q_ONE) + 32'(e_val);
        if (r_pw_c[31].kind == KIND_TANH) a_sel = Q_ONE - e_val;
        else if (r_pw_c[31].neg) a_sel = e_val;
        else a_sel = Q_ONE;
        num0  = ((F+32)'(a_sel) << F) + (F+32)'(den0 >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_dv_v[0] <= 1'b0;
        else if (adv) r_dv_v[0] <= r_pw_v[31];
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dv_c[0]   <= r_pw_c[31];
            r_dv_den[0] <= den0;
            r_dv_rem[0] <= 32'(num0[F+31:F+1]);
            r_dv_low[0] <= num0[F:0];
            r_dv_q[0]   <= '0;
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar j = 0; j <= F; j++) begin : g_dv
        logic [32:0] sh;
        logic        ge;
        assign sh = {r_dv_rem[j], r_dv_low[j][F]};
        assign ge = (sh >= {1'b0, r_dv_den[j]});
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_dv_v[j+1] <= 1'b0;
            else if (adv) r_dv_v[j+1] <= r_dv_v[j];
        end
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_dv_c[j+1]   <= r_dv_c[j];
                r_dv_den[j+1] <= r_dv_den[j];
                r_dv_rem[j+1] <= ge ? 32'(sh - {1'b0, r_dv_den[j]}) : sh[31:0];
                r_dv_low[j+1] <= r_dv_low[j] << 1;
                r_dv_q[j+1]   <= {r_dv_q[j][F-1:0], ge};
            end
        end
    end

    logic [F:0] mop;
    assign mop = (r_dv_c[F+1].kind == KIND_TANH) ? r_dv_q[F+1] : ONE_Q - r_dv_q[F+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ml_v <= 1'b0;
        else if (adv) r_ml_v <= r_dv_v[F+1];
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ml_c <= r_dv_c[F+1];
            r_ml_q <= r_dv_q[F+1];
            r_ml_p <= r_dv_q[F+1] * mop;
        end
    end

    logic [2*F+1:0]          rnd;
    logic signed [RES_W-1:0] qs;
    logic signed [RES_W-1:0] rs;
    logic signed [RES_W-1:0] res;
    logic [DW-1:0]           n_out;

    always_comb begin
        rnd = (r_ml_p + HALF_P) >> F;
        qs  = RES_W'(r_ml_q);
        rs  = RES_W'(rnd[F+1:0]);
        unique case (r_ml_c.kind)
            KIND_TANH: begin
                if (r_ml_c.der) res = ONE_S - rs;
                else res = r_ml_c.neg ? -qs : qs;
            end
            KIND_SIGMOID: res = r_ml_c.der ? rs : qs;
            default:      res = r_ml_c.res;
        endcase
        if (res > HI_S) n_out = HI_S[DW-1:0];
        else if (res < LO_S) n_out = LO_S[DW-1:0];
        else n_out = res[DW-1:0];
    end

    adu_fifo #(
        .WIDTH (DW),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_ml_v && adv),
        .i_wdata (n_out),
        .o_full  (ofull),
        .i_pop   (i_pop),
        .o_empty (o_empty),
        .o_rdata (o_value_out)
    );
endmodule
`default_nettype wire

// ===== hdl/activation_and_derivative_unit.sv =====
// Depth from request accept to result on the ports is set by the exp series,
// the exp(-1) power chain and the bit-per-stage divider, which grows with
// FRAC_BITS (Q3.12 by default). Throughput: one request per cycle while
// the result queue has room.
// Reset (i_rst_n, synchronous, active low): empties both queues and the
// pipeline, max_error to 0 and error_threshold to 3277.
`default_nettype none
module activation_and_derivative_unit import adu_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int MID_DEPTH  = MID_DEPTH_DEF,
    parameter int OUT_DEPTH  = OUT_DEPTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // request side
    input  wire logic                  push,
    output logic                       full,
    input  wire logic [DATA_WIDTH-1:0] i_value_in,
    input  wire logic [2:0]            i_mode,
    input  wire logic                  i_want_derivative,
    // result side
    output logic                       empty,
    input  wire logic                  pop,
    output logic [DATA_WIDTH-1:0]      o_value_out,
    // configuration writes
    input  wire logic                  i_cfg_we,
    input  wire logic [IDX_W-1:0]      i_cfg_idx,
    input  wire logic [REG_W-1:0]      i_cfg_data
);
    // Front: decode the mode, finish the piecewise-linear modes outright and
    // prepare the exp argument for tanh and sigmoid.
    logic  fr_valid;
    t_item fr_item;
    logic  mq_full;
    logic  mq_empty;
    t_item mq_item;
    logic  bk_take;

    adu_front #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_push            (push),
        .o_full            (full),
        .i_value_in        (i_value_in),
        .i_mode            (i_mode),
        .i_want_derivative (i_want_derivative),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .o_valid           (fr_valid),
        .o_item            (fr_item),
        .i_q_full          (mq_full)
    );

    // Hold classified requests here so front and back stall independently.
    adu_fifo #(
        .WIDTH ($bits(t_item)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_valid),
        .i_wdata (fr_item),
        .o_full  (mq_full),
        .i_pop   (bk_take),
        .o_empty (mq_empty),
        .o_rdata (mq_item)
    );

    // Back: exp series, power chain, divider and product; every request
    // flows through it so results leave in order. Advance only while the
    // result queue has room.
    adu_back #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .OUT_DEPTH  (OUT_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_avail     (!mq_empty),
        .i_item      (mq_item),
        .o_take      (bk_take),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_value_out (o_value_out)
    );
endmodule
`default_nettype wire
